### rtl/core/sacrl_pkg.sv
package sacrl_pkg;

    // Field widths of the stream payloads
    localparam int ADDR_IN_W   = 8;
    localparam int SET_OUT_W   = 2;
    localparam int TAG_OUT_W   = 3;
    localparam int WAY_OUT_W   = 1;
    localparam int FILL_OUT_W  = 8;
    localparam int COUNT_W     = 16;

    // m_axis_tdata layout, lowest field first
    localparam int SET_LSB     = 0;
    localparam int TAG_LSB     = SET_LSB + SET_OUT_W;
    localparam int WAY_LSB     = TAG_LSB + TAG_OUT_W;
    localparam int FILL_LSB    = WAY_LSB + WAY_OUT_W;
    localparam int HITS_LSB    = FILL_LSB + FILL_OUT_W;
    localparam int MISSES_LSB  = HITS_LSB + COUNT_W;
    localparam int OUT_USED_W  = MISSES_LSB + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int SEED_W      = 16;
    localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;
    localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;

    // Register indexes (paddr[2] selects the 32-bit word)
    localparam logic REG_VICTIM_SEED = 1'b0;

    // Parameter defaults
    localparam int DEF_SETS        = 4;
    localparam int DEF_WAYS        = 2;
    localparam int DEF_BLOCK_BYTES = 8;
    localparam int DEF_ADDR_BITS   = 8;

endpackage

### rtl/core/set_assoc_cache_read_lookup.sv
// Read lookup of a set-associative cache directory with random replacement. Each
// s_axis transfer carries a byte address, split into block offset, set index and
// tag; all ways of the selected set are compared in parallel and one result
// transfer per access reports hit or miss, the set and tag, and on a miss the way
// that gets filled (lowest invalid way, else an LFSR pick) and the block-aligned
// fill address, together with saturating hit and miss totals. The block accepts
// one access per cycle unless m_axis_tready holds back the result; the access is
// registered in the input stage, then in the result stage. Tag compare and
// directory update of the set happen as it advances, so the next access sees the
// previous fill. Writing victim_seed (APB, offset 0) reloads the LFSR at once; a zero seed loads as 1.
module set_assoc_cache_read_lookup #(
    parameter int SETS        = sacrl_pkg::DEF_SETS,
    parameter int WAYS        = sacrl_pkg::DEF_WAYS,
    parameter int BLOCK_BYTES = sacrl_pkg::DEF_BLOCK_BYTES,
    parameter int ADDR_BITS   = sacrl_pkg::DEF_ADDR_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] address
    input  logic [sacrl_pkg::ADDR_IN_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] set_index, [4:2] tag_value, [5] victim_way, [13:6] fill_address,
    // [29:14] hit_total, [45:30] miss_total, [47:46] zero
    output logic [sacrl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] hit
    output logic                                m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sacrl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sacrl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sacrl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import sacrl_pkg::*;

    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned TAG_SPAN = BLOCK_BYTES * SETS;
    localparam longint unsigned TAG_MAX =
        ((longint'(1) << ADDR_BITS) - 1) / longint'(TAG_SPAN);
    localparam int TAG_W    = (TAG_MAX > 0) ? $clog2(TAG_MAX + 1) : 1;

    // Input stage
    logic                 in_valid_reg;
    logic [ADDR_BITS-1:0] in_addr_reg;

    // Directory
    logic [TAG_W-1:0]     way_tags_mem [SETS][WAYS];
    logic [WAYS-1:0]      way_valid_reg [SETS];

    logic [SEED_W-1:0]    seed_reg;
    logic [SEED_W-1:0]    lfsr_reg;
    logic [COUNT_W-1:0]   hit_cnt_reg;
    logic [COUNT_W-1:0]   miss_cnt_reg;

    // Result stage
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [SET_OUT_W-1:0] out_set_reg;
    logic [TAG_OUT_W-1:0] out_tag_reg;
    logic [WAY_OUT_W-1:0] out_way_reg;
    logic [FILL_OUT_W-1:0] out_fill_reg;

    // Lookup logic
    logic                 advance;
    logic [SET_W-1:0]     set_idx;
    logic [TAG_W-1:0]     tag;
    logic [WAYS-1:0]      row_valid;
    logic                 hit;
    logic                 free_found;
    logic [WAY_W-1:0]     free_way;
    logic [SEED_W-1:0]    lfsr_step;
    logic                 use_random;
    logic [WAY_W-1:0]     victim;
    logic [ADDR_BITS-1:0] fill;
    logic [COUNT_W-1:0]   hit_cnt_next;
    logic [COUNT_W-1:0]   miss_cnt_next;
    logic                 cfg_write;
    logic [SEED_W-1:0]    seed_wr;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign set_idx = SET_W'((in_addr_reg / BLOCK_BYTES) % SETS);
    assign tag     = TAG_W'(in_addr_reg / TAG_SPAN);
    assign row_valid = way_valid_reg[set_idx];

    always_comb begin
        hit        = 1'b0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (row_valid[w] && (way_tags_mem[set_idx][w] == tag)) begin
                hit = 1'b1;
            end
            if (!row_valid[w] && !free_found) begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end
    end

    assign lfsr_step  = {1'b0, lfsr_reg[SEED_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign use_random = !hit && !free_found;

    always_comb begin
        priority if (hit) begin
            victim = '0;
        end else if (free_found) begin
            victim = free_way;
        end else begin
            victim = WAY_W'(lfsr_step % WAYS);
        end
    end

    assign fill = hit ? '0 : (in_addr_reg - ADDR_BITS'(in_addr_reg % BLOCK_BYTES));

    assign hit_cnt_next  = (hit && (hit_cnt_reg != '1)) ? hit_cnt_reg + 1'b1 : hit_cnt_reg;
    assign miss_cnt_next = (!hit && (miss_cnt_reg != '1)) ? miss_cnt_reg + 1'b1
                                                          : miss_cnt_reg;

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_VICTIM_SEED);
    assign seed_wr   = pwdata[SEED_W-1:0];
    assign prdata    = (paddr[2] == REG_VICTIM_SEED) ? APB_DATA_W'(seed_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= SEED_RESET;
            lfsr_reg      <= SEED_RESET;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            for (int s = 0; s < SETS; s++) begin
                way_valid_reg[s] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write) begin
                seed_reg <= seed_wr;
                lfsr_reg <= (seed_wr == '0) ? SEED_W'(1) : seed_wr;
            end else if (advance && use_random) begin
                lfsr_reg <= lfsr_step;
            end
            if (advance) begin
                hit_cnt_reg  <= hit_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
                if (!hit) begin
                    way_valid_reg[set_idx][victim] <= 1'b1;
                end
            end
        end
    end

    // Payload and tag storage, no reset
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_addr_reg <= ADDR_BITS'(s_axis_tdata);
        end
        if (advance) begin
            out_hit_reg  <= hit;
            out_set_reg  <= SET_OUT_W'(32'(set_idx));
            out_tag_reg  <= TAG_OUT_W'(32'(tag));
            out_way_reg  <= WAY_OUT_W'(32'(victim));
            out_fill_reg <= FILL_OUT_W'(32'(fill));
            if (!hit) begin
                way_tags_mem[set_idx][victim] <= tag;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({miss_cnt_reg, hit_cnt_reg, out_fill_reg,
                                         out_way_reg, out_tag_reg, out_set_reg});

endmodule
